@@ hdl/pcm48_pkg.sv @@
// ----------------------------------------------------------------------------
// pcm48_pkg
// Shared types, constants and register codes of the PCM to 48k converter.
// ----------------------------------------------------------------------------
package pcm48_pkg;

  // default output rate and run limits
  localparam int OUTPUT_RATE_DEF = 48000;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int MAX_RUN         = 6;
  localparam int MIN_RATE        = 8000;

  // field widths
  localparam int BYTE_W  = 8;
  localparam int SAMP_W  = 16;
  localparam int RATE_W  = 18;
  localparam int PHASE_W = 19;   // holds phase below the output rate plus one step
  localparam int CNT_W   = 3;
  localparam int CHAN_W  = 3;
  localparam int WCODE_W = 2;
  localparam int CCNT_W  = 4;
  localparam int IDX_W   = 2;

  // register indexes
  localparam logic [IDX_W-1:0] REG_WIDTH_CODE = 2'd0;
  localparam logic [IDX_W-1:0] REG_CHAN_COUNT = 2'd1;
  localparam logic [IDX_W-1:0] REG_INPUT_RATE = 2'd2;

  // sample width codes
  localparam logic [WCODE_W-1:0] WIDTH_8BIT = 2'd0;

  // one finished input frame, already in signed 16-bit form
  typedef struct packed {
    logic signed [SAMP_W-1:0] left;
    logic signed [SAMP_W-1:0] right;
  } frame_t;

endpackage

@@ hdl/pcm48_in_if.sv @@
// ----------------------------------------------------------------------------
// pcm48_in_if
// Byte stream channel into the converter.
// ----------------------------------------------------------------------------
interface pcm48_in_if;
  logic                           valid;
  logic                           ready;
  logic [pcm48_pkg::BYTE_W-1:0]   data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

@@ hdl/pcm48_out_if.sv @@
// ----------------------------------------------------------------------------
// pcm48_out_if
// Stereo sample channel out of the converter.
// ----------------------------------------------------------------------------
interface pcm48_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [pcm48_pkg::SAMP_W-1:0]  left_sample;
  logic signed [pcm48_pkg::SAMP_W-1:0]  right_sample;
  logic                                 last_of_run;

  modport source (output valid, output left_sample, output right_sample,
                  output last_of_run, input ready);
  modport sink   (input valid, input left_sample, input right_sample,
                  input last_of_run, output ready);
endinterface

@@ hdl/pcm48_cfg_if.sv @@
// ----------------------------------------------------------------------------
// pcm48_cfg_if
// Register write channel of the converter.
// ----------------------------------------------------------------------------
interface pcm48_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [pcm48_pkg::IDX_W-1:0]        reg_index;
  logic [pcm48_pkg::RATE_W-1:0]       wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

@@ hdl/pcm48_front.sv @@
// ----------------------------------------------------------------------------
// pcm48_front
// Byte assembly: tracks byte and channel position, keeps the last two bytes
// of channels 0 and 1 and hands a finished frame to the queue.
// ----------------------------------------------------------------------------
module pcm48_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              byte_valid,
  input  logic [pcm48_pkg::BYTE_W-1:0]      byte_data,
  output logic                              byte_ready,
  input  logic [pcm48_pkg::WCODE_W-1:0]     width_code,
  input  logic [pcm48_pkg::CHAN_W-1:0]      last_chan,
  input  logic                              q_full,
  output logic                              q_push,
  output pcm48_pkg::frame_t                 q_entry
);

  logic [pcm48_pkg::WCODE_W-1:0] bis_r, bis_nxt;
  logic [pcm48_pkg::CHAN_W-1:0]  chan_r, chan_nxt;
  logic [pcm48_pkg::SAMP_W-1:0]  left_r, left_nxt;
  logic [pcm48_pkg::SAMP_W-1:0]  right_r, right_nxt;
  logic                          accept;
  logic                          sample_end;
  logic                          frame_end;
  logic [pcm48_pkg::SAMP_W-1:0]  left_s16;
  logic [pcm48_pkg::SAMP_W-1:0]  right_s16;

  // 8-bit data is unsigned: flip the sign bit of the top byte
  function automatic logic [pcm48_pkg::SAMP_W-1:0] to_s16(
    input logic [pcm48_pkg::SAMP_W-1:0] bytes,
    input logic [pcm48_pkg::WCODE_W-1:0] code
  );
    logic [pcm48_pkg::SAMP_W-1:0] res;
    if (code == pcm48_pkg::WIDTH_8BIT) begin
      res = {bytes[15:8] ^ 8'h80, 8'h00};
    end else begin
      res = bytes;
    end
    return res;
  endfunction

  assign byte_ready = !q_full;
  assign accept     = byte_valid && byte_ready;
  assign sample_end = (bis_r >= width_code);
  assign frame_end  = (chan_r >= last_chan);

  // position counters and byte history
  always_comb begin
    bis_nxt   = bis_r;
    chan_nxt  = chan_r;
    left_nxt  = left_r;
    right_nxt = right_r;
    if (accept) begin
      if (chan_r == 3'd0) begin
        left_nxt = {byte_data, left_r[15:8]};
      end else if (chan_r == 3'd1) begin
        right_nxt = {byte_data, right_r[15:8]};
      end
      if (!sample_end) begin
        bis_nxt = bis_r + 2'd1;
      end else begin
        bis_nxt = '0;
        chan_nxt = frame_end ? '0 : chan_r + 3'd1;
      end
    end
  end

  // frame out to the queue, mono copies left
  assign left_s16  = to_s16(left_nxt, width_code);
  assign right_s16 = to_s16(right_nxt, width_code);
  assign q_push    = accept && sample_end && frame_end;
  assign q_entry.left  = left_s16;
  assign q_entry.right = (last_chan == 3'd0) ? left_s16 : right_s16;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bis_r   <= '0;
      chan_r  <= '0;
      left_r  <= '0;
      right_r <= '0;
    end else begin
      bis_r   <= bis_nxt;
      chan_r  <= chan_nxt;
      left_r  <= left_nxt;
      right_r <= right_nxt;
    end
  end

endmodule

@@ hdl/pcm48_queue.sv @@
// ----------------------------------------------------------------------------
// pcm48_queue
// Short frame queue between byte assembly and the resampler.
// ----------------------------------------------------------------------------
module pcm48_queue #(
  parameter int DEPTH = pcm48_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  pcm48_pkg::frame_t  push_entry,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output pcm48_pkg::frame_t  head_entry
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  pcm48_pkg::frame_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_entry = mem[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // no push into a full queue, no pop from an empty one
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full && !pop |-> !push) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid) else $error("queue underflow");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> count_r == $past(count_r) + 1'b1) else $error("count slip");

endmodule

@@ hdl/pcm48_back.sv @@
// ----------------------------------------------------------------------------
// pcm48_back
// Nearest-neighbour resampler: per frame, emits output frames while the phase
// is below the output rate and the run is short of MAX_RUN, then steps it down.
// ----------------------------------------------------------------------------
module pcm48_back #(
  parameter int OUTPUT_RATE = pcm48_pkg::OUTPUT_RATE_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [pcm48_pkg::RATE_W-1:0]     rate,
  input  logic                             q_valid,
  input  pcm48_pkg::frame_t                q_entry,
  output logic                             q_pop,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [pcm48_pkg::SAMP_W-1:0] out_left,
  output logic signed [pcm48_pkg::SAMP_W-1:0] out_right,
  output logic                             out_last
);

  localparam logic [pcm48_pkg::PHASE_W-1:0] OUT_RATE_C =
    pcm48_pkg::PHASE_W'(OUTPUT_RATE);
  localparam logic [pcm48_pkg::CNT_W-1:0] RUN_LAST =
    pcm48_pkg::CNT_W'(pcm48_pkg::MAX_RUN - 1);

  logic                                busy_r, busy_nxt;
  pcm48_pkg::frame_t                   frame_r, frame_nxt;
  logic [pcm48_pkg::PHASE_W-1:0]       phase_r, phase_nxt;
  logic [pcm48_pkg::CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                                oval_r, oval_nxt;
  logic signed [pcm48_pkg::SAMP_W-1:0] oleft_r, oleft_nxt;
  logic signed [pcm48_pkg::SAMP_W-1:0] oright_r, oright_nxt;
  logic                                olast_r, olast_nxt;
  logic [pcm48_pkg::PHASE_W-1:0]       phase_add;
  logic [pcm48_pkg::PHASE_W-1:0]       phase_sub;
  logic                                emit;
  logic                                out_free;

  assign out_free  = !oval_r || out_ready;
  assign emit      = (phase_r < OUT_RATE_C) && (cnt_r <= RUN_LAST);
  assign phase_add = phase_r + {1'b0, rate};
  assign phase_sub = phase_r - OUT_RATE_C;
  assign q_pop     = !busy_r && q_valid;

  // run sequencer
  always_comb begin
    busy_nxt   = busy_r;
    frame_nxt  = frame_r;
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    oval_nxt   = oval_r && !out_ready;
    oleft_nxt  = oleft_r;
    oright_nxt = oright_r;
    olast_nxt  = olast_r;
    if (q_pop) begin
      busy_nxt  = 1'b1;
      frame_nxt = q_entry;
      cnt_nxt   = '0;
    end else if (busy_r) begin
      if (emit) begin
        if (out_free) begin
          oval_nxt   = 1'b1;
          oleft_nxt  = frame_r.left;
          oright_nxt = frame_r.right;
          olast_nxt  = !((phase_add < OUT_RATE_C) && (cnt_r < RUN_LAST));
          phase_nxt  = phase_add;
          cnt_nxt    = cnt_r + 1'b1;
        end
      end else begin
        // run done: step down, a cut run saturates to zero
        busy_nxt  = 1'b0;
        phase_nxt = (phase_r >= OUT_RATE_C) ? {1'b0, phase_sub[pcm48_pkg::RATE_W-1:0]} : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    frame_r  <= frame_nxt;
    oleft_r  <= oleft_nxt;
    oright_r <= oright_nxt;
    olast_r  <= olast_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      phase_r <= '0;
      cnt_r   <= '0;
      oval_r  <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      oval_r  <= oval_nxt;
    end
  end

  assign out_valid = oval_r;
  assign out_left  = oleft_r;
  assign out_right = oright_r;
  assign out_last  = olast_r;

  // run length stays within the limit
  a_run_limit: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= pcm48_pkg::CNT_W'(pcm48_pkg::MAX_RUN)) else $error("run too long");
  // between runs the phase fits its stored width
  a_phase_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> !phase_r[pcm48_pkg::PHASE_W-1]) else $error("phase overflow");
  // a frame ending its run flags the last beat
  a_last_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && emit && out_free && cnt_r == RUN_LAST |=> olast_r)
    else $error("missing last flag");

endmodule

@@ hdl/pcm_to_48k_stereo_converter_top.sv @@
// ----------------------------------------------------------------------------
// pcm_to_48k_stereo_converter_top
// Little-endian PCM byte stream to 48 kHz signed 16-bit stereo frames.
//
//   port     dir   beat contents
//   in_ch    in    data_byte
//   out_ch   out   left_sample, right_sample, last_of_run
//   cfg_ch   in    reg_index, wdata (0 width code, 1 channels, 2 input rate)
//
// One byte is taken per cycle while the two-entry frame queue has room.
// A frame-ending byte has the resampler pick the frame up, emit n output beats
// (0 to 6) and then step the phase before it pops the next frame.
// A stalled output holds the resampler; the queue then fills and stops input.
// Reset is synchronous and returns registers to 16 bit, 2 channels, 44100 Hz.
// ----------------------------------------------------------------------------
module pcm_to_48k_stereo_converter_top #(
  parameter int OUTPUT_RATE = pcm48_pkg::OUTPUT_RATE_DEF,
  parameter int QUEUE_DEPTH = pcm48_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  pcm48_in_if.sink    in_ch,
  pcm48_out_if.source out_ch,
  pcm48_cfg_if.sink   cfg_ch
);

  logic [pcm48_pkg::WCODE_W-1:0] width_code_r;
  logic [pcm48_pkg::CHAN_W-1:0]  last_chan_r;
  logic [pcm48_pkg::RATE_W-1:0]  rate_r;
  logic [pcm48_pkg::CHAN_W-1:0]  last_chan_wr;
  logic [pcm48_pkg::RATE_W-1:0]  rate_wr;
  logic [pcm48_pkg::CCNT_W-1:0]  ccount_wr;
  logic                          cfg_write;
  logic                          q_full;
  logic                          q_push;
  logic                          q_pop;
  logic                          q_valid;
  pcm48_pkg::frame_t             q_in;
  pcm48_pkg::frame_t             q_head;

  // register writes, stored already clamped
  assign cfg_ch.ready = 1'b1;
  assign cfg_write    = cfg_ch.valid && cfg_ch.ready;
  assign ccount_wr    = cfg_ch.wdata[pcm48_pkg::CCNT_W-1:0];

  always_comb begin
    priority if (ccount_wr == 4'd0) begin
      last_chan_wr = '0;
    end else if (ccount_wr > 4'd8) begin
      last_chan_wr = 3'd7;
    end else begin
      last_chan_wr = pcm48_pkg::CHAN_W'(ccount_wr - 4'd1);
    end
  end

  assign rate_wr = (cfg_ch.wdata < pcm48_pkg::RATE_W'(pcm48_pkg::MIN_RATE))
                 ? pcm48_pkg::RATE_W'(pcm48_pkg::MIN_RATE) : cfg_ch.wdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_code_r <= 2'd1;
      last_chan_r  <= 3'd1;
      rate_r       <= 18'd44100;
    end else if (cfg_write) begin
      unique case (cfg_ch.reg_index)
        pcm48_pkg::REG_WIDTH_CODE: width_code_r <= cfg_ch.wdata[pcm48_pkg::WCODE_W-1:0];
        pcm48_pkg::REG_CHAN_COUNT: last_chan_r  <= last_chan_wr;
        pcm48_pkg::REG_INPUT_RATE: rate_r       <= rate_wr;
        default: ;
      endcase
    end
  end

  // byte assembly
  pcm48_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (in_ch.valid),
    .byte_data  (in_ch.data_byte),
    .byte_ready (in_ch.ready),
    .width_code (width_code_r),
    .last_chan  (last_chan_r),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_entry    (q_in)
  );

  // frame queue
  pcm48_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_entry (q_head)
  );

  // resampler
  pcm48_back #(
    .OUTPUT_RATE (OUTPUT_RATE)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rate      (rate_r),
    .q_valid   (q_valid),
    .q_entry   (q_head),
    .q_pop     (q_pop),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_left  (out_ch.left_sample),
    .out_right (out_ch.right_sample),
    .out_last  (out_ch.last_of_run)
  );

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the PCM to 48k converter with byte streams under many register
// settings. A behavioral mirror of the converter predicts every stereo beat,
// and each beat out is checked field by field. Input and output sides idle at
// random. Registers change only while the converter is drained.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int LIMIT_CYCLES = 600000;
  localparam int DRAIN_CYCLES = 24;
  localparam int RANDOM_BYTES = 320;
  localparam int IDLE_PCT     = 14;
  localparam logic [pcm48_pkg::IDX_W-1:0] REG_SPARE = 2'd3;

  // one expected output beat
  typedef struct packed {
    logic signed [pcm48_pkg::SAMP_W-1:0] left;
    logic signed [pcm48_pkg::SAMP_W-1:0] right;
    logic                                last;
  } stereo_beat_t;

  logic clk;
  logic rst_n;

  pcm48_in_if  in_ch();
  pcm48_out_if out_ch();
  pcm48_cfg_if cfg_ch();

  pcm_to_48k_stereo_converter_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // mirror of the converter registers and stream state
  logic [pcm48_pkg::WCODE_W-1:0] width_code;
  logic [pcm48_pkg::CCNT_W-1:0]  chan_count;
  logic [pcm48_pkg::RATE_W-1:0]  in_rate;
  logic [1:0]                    byte_pos;
  logic [pcm48_pkg::CHAN_W-1:0]  chan_pos;
  logic [pcm48_pkg::SAMP_W-1:0]  left_hold;
  logic [pcm48_pkg::SAMP_W-1:0]  right_hold;
  logic [pcm48_pkg::RATE_W-1:0]  phase_acc;

  logic [pcm48_pkg::BYTE_W-1:0] byte_queue[$];
  stereo_beat_t                 frames_due[$];
  int                           errors;
  int                           frames_seen;
  int                           cycles;
  bit                           calm;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // raw sample bytes to signed 16 bit
  function automatic logic [pcm48_pkg::SAMP_W-1:0] widen(
    logic [pcm48_pkg::SAMP_W-1:0] raw, logic [pcm48_pkg::WCODE_W-1:0] code);
    if (code == pcm48_pkg::WIDTH_8BIT) begin
      return {raw[pcm48_pkg::SAMP_W-1 -: pcm48_pkg::BYTE_W] ^ 8'h80, 8'h00};
    end
    return raw;
  endfunction

  // advance the mirror by one stream byte and queue the beats it causes
  function automatic void convert_byte(logic [pcm48_pkg::BYTE_W-1:0] b);
    int chans;
    int rate;
    int acc;
    int n;
    logic [pcm48_pkg::SAMP_W-1:0] l;
    logic [pcm48_pkg::SAMP_W-1:0] r;
    stereo_beat_t beat;
    chans = (chan_count == 0) ? 1 : (chan_count > 8) ? 8 : int'(chan_count);
    rate = (in_rate < pcm48_pkg::MIN_RATE) ? pcm48_pkg::MIN_RATE : int'(in_rate);
    if (chan_pos == 0) left_hold = {b, left_hold[pcm48_pkg::SAMP_W-1:pcm48_pkg::BYTE_W]};
    else if (chan_pos == 1) right_hold = {b, right_hold[pcm48_pkg::SAMP_W-1:pcm48_pkg::BYTE_W]};
    if (byte_pos < width_code) begin
      byte_pos = byte_pos + 2'd1;
      return;
    end
    byte_pos = 2'd0;
    if (int'(chan_pos) < chans - 1) begin
      chan_pos = chan_pos + 3'd1;
      return;
    end
    chan_pos = '0;
    l = widen(left_hold, width_code);
    r = (chans > 1) ? widen(right_hold, width_code) : l;
    // nearest-neighbour run from the phase accumulator
    acc = int'(phase_acc);
    n = 0;
    while (acc < pcm48_pkg::OUTPUT_RATE_DEF && n < pcm48_pkg::MAX_RUN) begin
      beat.left  = l;
      beat.right = r;
      beat.last  = (acc + rate >= pcm48_pkg::OUTPUT_RATE_DEF) ||
                   (n + 1 == pcm48_pkg::MAX_RUN);
      frames_due.push_back(beat);
      n++;
      acc += rate;
    end
    if (acc >= pcm48_pkg::OUTPUT_RATE_DEF) acc -= pcm48_pkg::OUTPUT_RATE_DEF;
    else acc = 0;
    phase_acc = acc[pcm48_pkg::RATE_W-1:0];
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d (beat %0d, t=%0t)",
             what, got, want, frames_seen, $time);
    errors++;
  endtask

  // input driver: one byte per beat from the pending queue
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) convert_byte(in_ch.data_byte);
      if (!in_ch.valid || in_ch.ready) begin
        if (byte_queue.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          in_ch.valid     <= 1'b1;
          in_ch.data_byte <= byte_queue.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // output monitor with random back-pressure
  always @(posedge clk) begin
    stereo_beat_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (frames_due.size() == 0) begin
          report_mismatch("unexpected beat, left_sample", int'(out_ch.left_sample), 0);
        end else begin
          want = frames_due.pop_front();
          if (out_ch.left_sample !== want.left)
            report_mismatch("left_sample", int'(out_ch.left_sample), int'(want.left));
          if (out_ch.right_sample !== want.right)
            report_mismatch("right_sample", int'(out_ch.right_sample), int'(want.right));
          if (out_ch.last_of_run !== want.last)
            report_mismatch("last_of_run", int'(out_ch.last_of_run), int'(want.last));
        end
        frames_seen++;
      end
      out_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // wait until every byte is taken and every beat has come, then let it settle
  task automatic wait_idle();
    do @(posedge clk);
    while (byte_queue.size() != 0 || in_ch.valid || frames_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [pcm48_pkg::IDX_W-1:0] idx,
                           logic [pcm48_pkg::RATE_W-1:0] value);
    @(posedge clk);
    cfg_ch.reg_index <= idx;
    cfg_ch.wdata     <= value;
    cfg_ch.valid     <= 1'b1;
    do @(posedge clk);
    while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      pcm48_pkg::REG_WIDTH_CODE: width_code = value[pcm48_pkg::WCODE_W-1:0];
      pcm48_pkg::REG_CHAN_COUNT: chan_count = value[pcm48_pkg::CCNT_W-1:0];
      pcm48_pkg::REG_INPUT_RATE: in_rate = value;
      default: ;
    endcase
  endtask

  // random register setting, extremes and out-of-range values included
  task automatic configure_random(bit all_regs);
    logic [pcm48_pkg::RATE_W-1:0] v;
    if (all_regs || $urandom_range(0, 3) != 0) begin
      v = pcm48_pkg::RATE_W'($urandom_range(0, 3));
      if ($urandom_range(0, 5) == 0) v = pcm48_pkg::RATE_W'($urandom);
      write_reg(pcm48_pkg::REG_WIDTH_CODE, v);
    end
    if (all_regs || $urandom_range(0, 3) != 0) begin
      case ($urandom_range(0, 9))
        0:       v = '0;
        1:       v = pcm48_pkg::RATE_W'($urandom_range(9, 15));
        2:       v = pcm48_pkg::RATE_W'($urandom);
        default: v = pcm48_pkg::RATE_W'($urandom_range(1, 8));
      endcase
      write_reg(pcm48_pkg::REG_CHAN_COUNT, v);
    end
    if (all_regs || $urandom_range(0, 3) != 0) begin
      case ($urandom_range(0, 9))
        0:       v = pcm48_pkg::RATE_W'($urandom_range(0, pcm48_pkg::MIN_RATE - 1));
        1:       v = pcm48_pkg::RATE_W'(pcm48_pkg::MIN_RATE);
        2:       v = 18'd192000;
        3:       v = 18'h3FFFF;
        4:       v = pcm48_pkg::RATE_W'(pcm48_pkg::OUTPUT_RATE_DEF);
        default: v = pcm48_pkg::RATE_W'($urandom_range(pcm48_pkg::MIN_RATE, 192000));
      endcase
      write_reg(pcm48_pkg::REG_INPUT_RATE, v);
    end
    if ($urandom_range(0, 7) == 0) write_reg(REG_SPARE, pcm48_pkg::RATE_W'($urandom));
  endtask

  function automatic logic [pcm48_pkg::BYTE_W-1:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      3:       return 8'h7F;
      default: return pcm48_pkg::BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  // stimulus
  initial begin
    int total;
    int n_phase;
    int len;
    int i;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.data_byte  = '0;
    out_ch.ready     = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.reg_index = pcm48_pkg::REG_WIDTH_CODE;
    cfg_ch.wdata     = '0;
    width_code = 2'd1;
    chan_count = 4'd2;
    in_rate    = 18'd44100;
    byte_pos   = '0;
    chan_pos   = '0;
    left_hold  = '0;
    right_hold = '0;
    phase_acc  = '0;
    errors = 0;
    frames_seen = 0;
    cycles = 0;
    calm = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // after-reset setting: 16 bit stereo at 44.1k, full-scale and small samples
    byte_queue = '{8'h00, 8'h80, 8'hFF, 8'h7F, 8'h01, 8'h00, 8'hFE, 8'hFF};
    wait_idle();
    // 8 bit, channel count zero taken as mono, rate below minimum
    write_reg(pcm48_pkg::REG_WIDTH_CODE, pcm48_pkg::RATE_W'(pcm48_pkg::WIDTH_8BIT));
    write_reg(pcm48_pkg::REG_CHAN_COUNT, 18'd0);
    write_reg(pcm48_pkg::REG_INPUT_RATE, 18'd0);
    byte_queue = '{8'h00, 8'hFF, 8'h80, 8'h7F};
    wait_idle();
    // 24 bit mono at the top of the rate range
    write_reg(pcm48_pkg::REG_WIDTH_CODE, 18'd2);
    write_reg(pcm48_pkg::REG_CHAN_COUNT, 18'd1);
    write_reg(pcm48_pkg::REG_INPUT_RATE, 18'h3FFFF);
    byte_queue = '{8'h12, 8'h00, 8'h80, 8'h34, 8'hFF, 8'h7F};
    wait_idle();
    // 32 bit stereo at 192k
    write_reg(pcm48_pkg::REG_WIDTH_CODE, 18'd3);
    write_reg(pcm48_pkg::REG_CHAN_COUNT, 18'd2);
    write_reg(pcm48_pkg::REG_INPUT_RATE, 18'd192000);
    byte_queue = '{8'hAA, 8'h55, 8'hFF, 8'h7F, 8'h00, 8'h00, 8'h00, 8'h80};
    wait_idle();

    // random phases; a setting may change in the middle of a frame
    total = 0;
    n_phase = 0;
    while (total < RANDOM_BYTES) begin
      calm = (n_phase == 3 || n_phase == 4);
      configure_random(n_phase == 0);
      len = $urandom_range(16, 48);
      for (i = 0; i < len; i++) begin
        byte_queue.push_back(pick_byte());
        // hold the sender until everything predicted so far is out
        if (n_phase == 6 && i == len / 2) wait_idle();
      end
      total += len;
      n_phase++;
      wait_idle();
    end
    calm = 1'b0;

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
